>>> hdl/etc_pkg.sv
// ---------------------------------------------------------------------------
// Escape-time colorizer package
// Shared constants, register indexes and types of the pixel colorizer.
// ---------------------------------------------------------------------------
package etc_pkg;

    localparam int ITER_BITS       = 16;
    localparam int COORD_FRAC_BITS = 24;
    localparam int CFG_DATA_W      = 16;
    localparam int LG_FRAC         = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [1:0] CFG_PALETTE  = 2'd1;
    localparam logic [1:0] CFG_PHASE    = 2'd2;

    localparam logic [15:0] MAX_ITER_RESET = 16'd64;

    // Log2 offsets, Q.16.
    localparam int L2_OFFSET = (2 * COORD_FRAC_BITS) << LG_FRAC;
    localparam int G_OFFSET  = (18 << LG_FRAC) + 34653;

    localparam logic [16:0] INV_LN2_Q16     = 17'd94548;
    localparam logic [28:0] TURN_FREQ_Q32   = 29'd382796555;
    localparam logic [29:0] INV_2PI_Q32     = 30'd683565276;
    localparam logic [18:0] TWO_PI_Q16      = 19'd411775;
    localparam logic [15:0] CORDIC_GAIN_Q16 = 16'd39797;

    typedef struct packed {
        logic at_max;
        logic palette;
    } etc_flags_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } etc_rot_t;

endpackage

>>> hdl/escape_time_pixel_colorizer.sv
// A pixel colorizer that takes one word per clock unless in_stall is high and
// returns each colored pixel in order. The pipeline runs through the two 18-stage
// log2 pipes (one squaring multiplier per stage after search and normalization),
// the 9-stage green divider and the 11-stage cosine unit. The whole pipeline holds
// while the output word waits, so in_stall follows out_stall whenever a result is waiting.
// ---------------------------------------------------------------------------
// Escape-time pixel colorizer
// Plain green ramp or smooth cosine palette from escape count and final z.
// ---------------------------------------------------------------------------
module escape_time_pixel_colorizer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           iter_count,
    input  logic signed [31:0]    z_real,
    input  logic signed [31:0]    z_imag,
    input  logic [31:0]           base_color,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           pixel_color
);
    import etc_pkg::*;

    localparam int DIV_SIDE_W = 32 + 32 + 32 + ITER_BITS + 2;
    localparam int LG1_SIDE_W = 32 + ITER_BITS + 2 + 8;
    localparam int LG2_SIDE_W = LG1_SIDE_W + 1;
    localparam int CD_SIDE_W  = 2 + 32 + 8;

    // Configuration.
    logic [15:0] max_iter_reg;
    logic        palette_reg;
    logic [15:0] phase_reg;
    logic [47:0] sh_reg;
    logic [47:0] sh2_reg;
    logic [49:0] sh_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
            palette_reg  <= 1'b0;
            phase_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_ITER: max_iter_reg <= cfg_data;
                CFG_PALETTE:  palette_reg  <= cfg_data[0];
                CFG_PHASE:    phase_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Phase shift in turns, Q.48, registered from the phase register.
    assign sh_next = {30'd0, phase_reg, 4'd0} * {20'd0, INV_2PI_Q32};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg  <= '0;
            sh2_reg <= '0;
        end
        else
        begin
            sh_reg  <= sh_next[47:0];
            sh2_reg <= {sh_next[46:0], 1'b0};
        end
    end

    logic adv;
    logic out_valid_reg;
    logic [31:0] pixel_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Stage 1: capture, magnitudes and flags.
    logic                 s1_valid_reg;
    logic [31:0]          s1_ar_reg;
    logic [31:0]          s1_ai_reg;
    logic [31:0]          s1_base_reg;
    logic [ITER_BITS-1:0] s1_count_reg;
    etc_flags_t           s1_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ar_reg    <= z_real[31] ? 32'd0 - z_real : z_real;
            s1_ai_reg    <= z_imag[31] ? 32'd0 - z_imag : z_imag;
            s1_base_reg  <= base_color;
            s1_count_reg <= iter_count;
            s1_flags_reg <= '{at_max: iter_count == max_iter_reg, palette: palette_reg};
        end
    end

    // Green ramp.
    logic                  dv_valid;
    logic [7:0]            dv_green;
    logic [DIV_SIDE_W-1:0] dv_side;
    logic [31:0]           dv_ar;
    logic [31:0]           dv_ai;
    logic [31:0]           dv_base;
    logic [ITER_BITS-1:0]  dv_count;
    etc_flags_t            dv_flags;

    etc_ramp_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_ramp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .in_count  (s1_count_reg),
        .in_max    (max_iter_reg),
        .in_side   ({s1_ar_reg, s1_ai_reg, s1_base_reg, s1_count_reg, s1_flags_reg}),
        .out_valid (dv_valid),
        .out_green (dv_green),
        .out_side  (dv_side)
    );

    assign {dv_ar, dv_ai, dv_base, dv_count, dv_flags} = dv_side;

    // Stages 2 and 3: |z|^2.
    logic                  s2_valid_reg;
    logic [63:0]           s2_sqr_reg;
    logic [63:0]           s2_sqi_reg;
    logic [LG1_SIDE_W-1:0] s2_side_reg;
    logic                  s3_valid_reg;
    logic [63:0]           s3_r2_reg;
    logic [LG1_SIDE_W-1:0] s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= dv_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sqr_reg  <= {32'd0, dv_ar} * {32'd0, dv_ar};
            s2_sqi_reg  <= {32'd0, dv_ai} * {32'd0, dv_ai};
            s2_side_reg <= {dv_base, dv_count, dv_flags, dv_green};
            s3_r2_reg   <= s2_sqr_reg + s2_sqi_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // log2 of |z|^2.
    logic                  lg1_valid;
    logic [21:0]           lg1_log;
    logic [LG1_SIDE_W-1:0] lg1_side;

    etc_log2 #(
        .IN_W   (64),
        .SIDE_W (LG1_SIDE_W)
    ) u_log2_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .in_value  (s3_r2_reg),
        .in_side   (s3_side_reg),
        .out_valid (lg1_valid),
        .out_log   (lg1_log),
        .out_side  (lg1_side)
    );

    // Stage 4: log2 of |z|^2 less the coordinate scale; only a positive value gets smoothing.
    logic signed [22:0]    l2_next;
    logic                  pos_next;
    logic                  s4_valid_reg;
    logic [19:0]           s4_l2_reg;
    logic [LG2_SIDE_W-1:0] s4_side_reg;

    assign l2_next  = $signed({1'b0, lg1_log}) - $signed(23'(L2_OFFSET));
    assign pos_next = !l2_next[22] && (l2_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= lg1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_l2_reg   <= pos_next ? l2_next[19:0] : 20'd0;
            s4_side_reg <= {pos_next, lg1_side};
        end
    end

    logic                  lg2_valid;
    logic [20:0]           lg2_log;
    logic [LG2_SIDE_W-1:0] lg2_side;

    etc_log2 #(
        .IN_W   (20),
        .SIDE_W (LG2_SIDE_W)
    ) u_log2_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s4_valid_reg),
        .in_value  (s4_l2_reg),
        .in_side   (s4_side_reg),
        .out_valid (lg2_valid),
        .out_log   (lg2_log),
        .out_side  (lg2_side)
    );

    // Stage 5: smoothing term times 1/ln2.
    logic signed [22:0]   gq_next;
    logic signed [40:0]   prod_next;
    logic                 s5_valid_reg;
    logic signed [40:0]   s5_prod_reg;
    logic                 s5_pos_reg;
    logic [31:0]          s5_base_reg;
    logic [ITER_BITS-1:0] s5_count_reg;
    etc_flags_t           s5_flags_reg;
    logic [7:0]           s5_green_reg;

    assign gq_next   = $signed({2'b0, lg2_log}) - $signed(23'(G_OFFSET));
    assign prod_next = gq_next * $signed({1'b0, INV_LN2_Q16});

    // Stage 6: index A = (count + 1) - T, Q.16; T rounds toward zero.
    logic signed [40:0]   tadj_next;
    logic signed [24:0]   t_next;
    logic signed [34:0]   a_next;
    logic [16:0]          cnt1_next;
    logic                 s6_valid_reg;
    logic signed [34:0]   s6_a_reg;
    logic [CD_SIDE_W-1:0] s6_side_reg;

    assign tadj_next = s5_prod_reg + (s5_prod_reg[40] ? 41'sd65535 : 41'sd0);
    assign t_next    = s5_pos_reg ? tadj_next[40:16] : 25'sd0;
    assign cnt1_next = {1'b0, s5_count_reg} + 17'd1;
    assign a_next    = $signed({2'b0, cnt1_next, 16'd0}) - $signed({{10{t_next[24]}}, t_next});

    // Stage 7: A times 0.56/(2pi), split in two 24-bit halves modulo 2^48.
    logic [47:0]          a48;
    logic [52:0]          plo_next;
    logic [52:0]          phi_next;
    logic                 s7_valid_reg;
    logic [47:0]          s7_plo_reg;
    logic [23:0]          s7_phi_reg;
    logic [CD_SIDE_W-1:0] s7_side_reg;

    assign a48      = {{13{s6_a_reg[34]}}, s6_a_reg};
    assign plo_next = {29'd0, a48[23:0]} * {24'd0, TURN_FREQ_Q32};
    assign phi_next = {29'd0, a48[47:24]} * {24'd0, TURN_FREQ_Q32};

    // Stages 8 and 9: phase of each channel.
    logic                 s8_valid_reg;
    logic [47:0]          idx_reg;
    logic [CD_SIDE_W-1:0] s8_side_reg;
    logic [47:0]          idx1_next;
    logic [47:0]          idx2_next;
    logic                 s9_valid_reg;
    logic [2:0][31:0]     s9_phase_reg;
    logic [CD_SIDE_W-1:0] s9_side_reg;

    assign idx1_next = idx_reg + sh_reg;
    assign idx2_next = idx_reg + sh2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_valid_reg <= lg2_valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_prod_reg <= prod_next;
            {s5_pos_reg, s5_base_reg, s5_count_reg, s5_flags_reg, s5_green_reg} <= lg2_side;
            s6_a_reg    <= a_next;
            s6_side_reg <= {s5_flags_reg, s5_base_reg, s5_green_reg};
            s7_plo_reg  <= plo_next[47:0];
            s7_phi_reg  <= phi_next[23:0];
            s7_side_reg <= s6_side_reg;
            idx_reg     <= s7_plo_reg + {s7_phi_reg, 24'd0};
            s8_side_reg <= s7_side_reg;
            s9_phase_reg[2] <= idx_reg[47:16];
            s9_phase_reg[1] <= idx1_next[47:16];
            s9_phase_reg[0] <= idx2_next[47:16];
            s9_side_reg <= s8_side_reg;
        end
    end

    // Cosine channels: index 2 red, 1 green, 0 blue.
    logic                 cd_valid;
    logic [2:0][7:0]      cd_chan;
    logic [CD_SIDE_W-1:0] cd_side;
    etc_flags_t           cd_flags;
    logic [31:0]          cd_base;
    logic [7:0]           cd_green;

    etc_cordic #(
        .SIDE_W (CD_SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s9_valid_reg),
        .in_phase  (s9_phase_reg),
        .in_side   (s9_side_reg),
        .out_valid (cd_valid),
        .out_chan  (cd_chan),
        .out_side  (cd_side)
    );

    assign {cd_flags, cd_base, cd_green} = cd_side;

    // Output word register.
    logic [31:0] pixel_next;

    always_comb
    begin
        priority if (cd_flags.at_max)
        begin
            pixel_next = '0;
        end
        else if (!cd_flags.palette)
        begin
            pixel_next = {cd_base[31:16], cd_green, cd_base[7:0]};
        end
        else
        begin
            pixel_next = {cd_base[31:24], cd_chan[2], cd_chan[1], cd_chan[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = pixel_reg;

    a_black_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cd_valid && cd_flags.at_max |=> out_valid && pixel_color == '0)
        else $error("pixel at the iteration limit is not black");

    a_plain_keeps_base: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cd_valid && !cd_flags.at_max && !cd_flags.palette |=>
        pixel_color[31:16] == $past(cd_base[31:16]) && pixel_color[7:0] == $past(cd_base[7:0]))
        else $error("plain mode changed a channel other than green");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s9_valid_reg) && $stable(s1_valid_reg))
        else $error("pipeline moved while the output word was stalled");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting output word");

endmodule

>>> hdl/etc_ramp_div.sv
// ---------------------------------------------------------------------------
// Green ramp divider
// Pipelined restoring division giving floor(count*255/max), saturated at 255.
// ---------------------------------------------------------------------------
module etc_ramp_div #(
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [15:0]       in_count,
    input  logic [15:0]       in_max,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [7:0]        out_green,
    output logic [SIDE_W-1:0] out_side
);
    import etc_pkg::*;

    logic [23:0]       rem_reg  [0:8];
    logic [7:0]        q_reg    [0:8];
    logic              ovf_reg  [0:8];
    logic              val_reg  [0:8];
    logic [SIDE_W-1:0] side_reg [0:8];

    logic [23:0] num_next;
    logic        ovf_next;

    assign num_next = {in_count, 8'd0} - {8'd0, in_count};
    assign ovf_next = num_next >= {in_max, 8'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            val_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= num_next;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= in_side;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < 8; s++)
    begin : g_bit
        logic [23:0] dvs;
        logic        ge;

        assign dvs = {8'd0, in_max} << (7 - s);
        assign ge  = rem_reg[s] >= dvs;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                val_reg[s+1] <= val_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1]  <= ge ? rem_reg[s] - dvs : rem_reg[s];
                q_reg[s+1]    <= {q_reg[s][6:0], ge};
                ovf_reg[s+1]  <= ovf_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = val_reg[8];
    assign out_green = ovf_reg[8] ? 8'hFF : q_reg[8];
    assign out_side  = side_reg[8];

endmodule

>>> hdl/etc_log2.sv
// ---------------------------------------------------------------------------
// Pipelined log2
// Q.16 log2: leading-one search, normalization, then one squaring per stage.
// ---------------------------------------------------------------------------
module etc_log2 #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [IN_W-1:0]               in_value,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [$clog2(IN_W)+15:0]      out_log,
    output logic [SIDE_W-1:0]             out_side
);
    import etc_pkg::*;

    localparam int E_W = $clog2(IN_W);
    localparam int NSQ = LG_FRAC;

    logic [E_W-1:0]    msb_next;
    logic [IN_W-1:0]   v0_reg;
    logic [E_W-1:0]    e0_reg;
    logic              val0_reg;
    logic [SIDE_W-1:0] side0_reg;
    logic [IN_W+31:0]  norm_next;

    logic [31:0]       m_reg    [0:NSQ];
    logic [NSQ-1:0]    frac_reg [0:NSQ];
    logic [E_W-1:0]    e_reg    [0:NSQ];
    logic              val_reg  [0:NSQ];
    logic [SIDE_W-1:0] side_reg [0:NSQ];

    always_comb
    begin
        msb_next = '0;
        for (int k = 0; k < IN_W; k++)
        begin
            if (in_value[k])
            begin
                msb_next = E_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val0_reg   <= 1'b0;
            val_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            val0_reg   <= in_valid;
            val_reg[0] <= val0_reg;
        end
    end

    // Leading one moves to bit 31 of the mantissa.
    assign norm_next = {v0_reg, 32'd0} << (E_W'(IN_W - 1) - e0_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v0_reg      <= in_value;
            e0_reg      <= msb_next;
            side0_reg   <= in_side;
            m_reg[0]    <= norm_next[IN_W+31 -: 32];
            frac_reg[0] <= '0;
            e_reg[0]    <= e0_reg;
            side_reg[0] <= side0_reg;
        end
    end

    for (genvar s = 0; s < NSQ; s++)
    begin : g_sq
        logic [63:0] sq;

        assign sq = {32'd0, m_reg[s]} * {32'd0, m_reg[s]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                val_reg[s+1] <= val_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[s+1]    <= sq[63] ? sq[63:32] : sq[62:31];
                frac_reg[s+1] <= {frac_reg[s][NSQ-2:0], sq[63]};
                e_reg[s+1]    <= e_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = val_reg[NSQ];
    assign out_log   = {e_reg[NSQ], frac_reg[NSQ]};
    assign out_side  = side_reg[NSQ];

endmodule

>>> hdl/etc_cordic.sv
// ---------------------------------------------------------------------------
// Cosine channel unit
// Three CORDIC cosines, two rotations per stage, scaled to channel bytes.
// ---------------------------------------------------------------------------
module etc_cordic #(
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [2:0][31:0]  in_phase,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [2:0][7:0]   out_chan,
    output logic [SIDE_W-1:0] out_side
);
    import etc_pkg::*;

    function automatic logic signed [31:0] atan_q16(input int unsigned i);
        logic signed [31:0] v;
        unique case (i)
            0:  v = 32'sd51472;
            1:  v = 32'sd30386;
            2:  v = 32'sd16055;
            3:  v = 32'sd8150;
            4:  v = 32'sd4091;
            5:  v = 32'sd2047;
            6:  v = 32'sd1024;
            7:  v = 32'sd512;
            8:  v = 32'sd256;
            9:  v = 32'sd128;
            10: v = 32'sd64;
            11: v = 32'sd32;
            12: v = 32'sd16;
            13: v = 32'sd8;
            14: v = 32'sd4;
            15: v = 32'sd2;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic etc_rot_t rotate(input etc_rot_t r, input int unsigned i);
        etc_rot_t           o;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        xs = r.x >>> i;
        ys = r.y >>> i;
        if (!r.z[31])
        begin
            o.x = r.x - ys;
            o.y = r.y + xs;
            o.z = r.z - atan_q16(i);
        end
        else
        begin
            o.x = r.x + ys;
            o.y = r.y - xs;
            o.z = r.z + atan_q16(i);
        end
        return o;
    endfunction

    logic              a_val_reg;
    logic [31:0]       a_mag_reg [0:2];
    logic              a_neg_reg [0:2];
    logic [SIDE_W-1:0] a_side_reg;

    etc_rot_t          rot_reg  [0:8][0:2];
    logic              neg_reg  [0:8][0:2];
    logic              val_reg  [0:8];
    logic [SIDE_W-1:0] side_reg [0:8];

    logic              out_val_reg;
    logic [2:0][7:0]   chan_reg;
    logic [SIDE_W-1:0] out_side_reg;
    logic [2:0][7:0]   chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_val_reg   <= 1'b0;
            val_reg[0]  <= 1'b0;
            out_val_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_val_reg   <= in_valid;
            val_reg[0]  <= a_val_reg;
            out_val_reg <= val_reg[8];
        end
    end

    // Fold the phase to a quarter turn around zero; the far half flips sign.
    for (genvar c = 0; c < 3; c++)
    begin : g_fold
        logic        neg;
        logic [31:0] f;
        logic [50:0] ang;

        assign neg = in_phase[c][31] ^ in_phase[c][30];
        assign f   = {in_phase[c][31] ^ neg, in_phase[c][30:0]};
        assign ang = {19'd0, a_mag_reg[c]} * {32'd0, TWO_PI_Q16};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_neg_reg[c]  <= neg;
                a_mag_reg[c]  <= f[31] ? 32'd0 - f : f;
                rot_reg[0][c] <= '{x: $signed({16'd0, CORDIC_GAIN_Q16}),
                                   y: 32'sd0,
                                   z: $signed({13'd0, ang[50:32]})};
                neg_reg[0][c] <= a_neg_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg  <= in_side;
            side_reg[0] <= a_side_reg;
        end
    end

    for (genvar s = 0; s < 8; s++)
    begin : g_rot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                val_reg[s+1] <= val_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rot_reg[s+1][c] <= rotate(rotate(rot_reg[s][c], 2 * s), 2 * s + 1);
                    neg_reg[s+1][c] <= neg_reg[s][c];
                end
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    always_comb
    begin
        logic signed [31:0] xc;
        logic signed [31:0] cv;
        logic signed [31:0] lvl;
        chan_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            xc = rot_reg[8][c].x;
            if (xc < 0)
            begin
                xc = 32'sd0;
            end
            else if (xc > 32'sd65536)
            begin
                xc = 32'sd65536;
            end
            cv  = neg_reg[8][c] ? -xc : xc;
            lvl = 32'sd8388608 + (cv <<< 7) - cv;
            chan_next[c] = lvl[23:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            chan_reg     <= chan_next;
            out_side_reg <= side_reg[8];
        end
    end

    assign out_valid = out_val_reg;
    assign out_chan  = chan_reg;
    assign out_side  = out_side_reg;

endmodule

>>> tb/escape_time_pixel_colorizer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Escape-time pixel colorizer testbench
// Drives pixel words through the colorizer under several idling patterns and
// register settings, and compares every colored pixel with a local predictor.
// ---------------------------------------------------------------------------
module escape_time_pixel_colorizer_test;
    import etc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] iter_count;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
    logic [31:0] base_color;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] pixel_color;

    // Predictor copy of the registers.
    logic [15:0] pred_max_iter;
    logic        pred_palette;
    logic [15:0] pred_phase;

    logic [31:0] expected_pixels[$];
    int          error_count;
    int          idle_sender_pct;
    int          stall_receiver_pct;
    int          quiet_cycles;

    escape_time_pixel_colorizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .iter_count  (iter_count),
        .z_real      (z_real),
        .z_imag      (z_imag),
        .base_color  (base_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_color (pixel_color)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Q.16 base-2 logarithm by repeated squaring of the mantissa.
    function automatic longint log2_q16(input logic [63:0] v);
        int          msb;
        logic [63:0] mant;
        longint      frac;
        begin
            msb  = 0;
            frac = 0;
            for (int i = 63; i > 0; i--)
            begin
                if (v[i] && msb == 0)
                    msb = i;
            end
            if (msb >= 31)
                mant = v >> (msb - 31);
            else
                mant = v << (31 - msb);
            for (int k = 0; k < 16; k++)
            begin
                mant = (mant * mant) >> 31;
                frac = frac << 1;
                if (mant >= 64'h1_0000_0000)
                begin
                    mant = mant >> 1;
                    frac = frac | 1;
                end
            end
            return (longint'(msb) << 16) | frac;
        end
    endfunction

    function automatic int cosine_q16(input logic [31:0] phase);
        logic        negate;
        logic [31:0] mag;
        int          x, y, z, t;
        int          atan_steps[16];
        begin
            atan_steps = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
            negate = ((phase + 32'h4000_0000) & 32'h8000_0000) != 0;
            if (negate)
                phase = phase - 32'h8000_0000;
            mag = phase[31] ? (32'd0 - phase) : phase;
            z = int'((64'(mag) * 64'(TWO_PI_Q16)) >> 32);
            x = CORDIC_GAIN_Q16;
            y = 0;
            for (int i = 0; i < 16; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - atan_steps[i];
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + atan_steps[i];
                end
                x = t;
            end
            if (x < 0)
                x = 0;
            if (x > 65536)
                x = 65536;
            return negate ? -x : x;
        end
    endfunction

    function automatic logic [7:0] palette_channel(input logic [63:0] turns);
        int          c;
        logic [31:0] v;
        begin
            c = cosine_q16(turns[47:16]);
            v = 32'(128 * 65536 + 127 * c);
            return v[23:16];
        end
    endfunction

    function automatic logic [31:0] colorize(input logic [15:0] cnt,
                                             input logic [31:0] zr,
                                             input logic [31:0] zi,
                                             input logic [31:0] base);
        logic [63:0] ar, ai, r2, angle, shift, green;
        longint      l2, g2, smooth, a;
        begin
            if (cnt == pred_max_iter)
                return 32'd0;
            if (!pred_palette)
            begin
                if (pred_max_iter == 0)
                    green = 255;
                else
                    green = (64'(cnt) * 255) / pred_max_iter;
                if (green > 255)
                    green = 255;
                return {base[31:16], green[7:0], base[7:0]};
            end
            ar = zr[31] ? 64'h1_0000_0000 - 64'(zr) : 64'(zr);
            ai = zi[31] ? 64'h1_0000_0000 - 64'(zi) : 64'(zi);
            r2 = ar * ar + ai * ai;
            smooth = 0;
            if (r2 != 0)
            begin
                l2 = log2_q16(r2) - (longint'(2 * COORD_FRAC_BITS) << 16);
                if (l2 > 0)
                begin
                    g2 = log2_q16(64'(l2)) - (longint'(18) << 16) - 34653;
                    smooth = (g2 * 94548) / 65536;
                end
            end
            a = (longint'(cnt) + 1) * 65536 - smooth;
            angle = 64'(a) * 64'(TURN_FREQ_Q32);
            shift = (64'(pred_phase) << 4) * 64'(INV_2PI_Q32);
            return {base[31:24], palette_channel(angle),
                    palette_channel(angle + shift),
                    palette_channel(angle + shift + shift)};
        end
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
            if (idx == CFG_MAX_ITER)
                pred_max_iter = value;
            else if (idx == CFG_PALETTE)
                pred_palette = value[0];
            else if (idx == CFG_PHASE)
                pred_phase = value;
        end
    endtask

    // Waits for the pipeline to empty before a register change.
    task automatic wait_idle;
        begin
            in_valid <= 1'b0;
            while (expected_pixels.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    task automatic send_pixel(input logic [15:0] cnt, input logic [31:0] zr,
                              input logic [31:0] zi, input logic [31:0] base);
        begin
            while ($urandom_range(99) < idle_sender_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid   <= 1'b1;
            iter_count <= cnt;
            z_real     <= zr;
            z_imag     <= zi;
            base_color <= base;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            expected_pixels.push_back(colorize(cnt, zr, zi, base));
            @(negedge clk);
        end
    endtask

    // Random z: half within +-4.0, a quarter whole values up to +-100, a quarter anywhere.
    function automatic logic [31:0] random_coord;
        begin
            case ($urandom_range(3))
                0: return $urandom;
                1: return 32'($signed($urandom_range(200)) - 100) << 24;
                default: return 32'($signed($urandom_range(32'h0800_0000))
                                    - 32'sh0400_0000);
            endcase
        end
    endfunction

    function automatic logic [15:0] random_count;
        begin
            case ($urandom_range(4))
                0: return pred_max_iter;
                1: return 16'($urandom);
                default: return 16'($urandom_range(32'(pred_max_iter) + 2));
            endcase
        end
    endfunction

    task automatic send_random_pixels(input int n);
        begin
            for (int i = 0; i < n; i++)
                send_pixel(random_count(), random_coord(), random_coord(), $urandom);
            in_valid <= 1'b0;
        end
    endtask

    task automatic test_plain_ramp_extremes;
        begin
            send_pixel(16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
            send_pixel(16'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
            send_pixel(16'd64, 32'd0, 32'd0, 32'hFFFF_FFFF);
            send_pixel(16'd65, 32'd0, 32'd0, 32'hA5A5_A5A5);
            send_pixel(16'hFFFF, 32'd0, 32'd0, 32'h5A5A_5A5A);
            wait_idle();
            write_register(CFG_MAX_ITER, 16'd0);
            send_pixel(16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
            send_pixel(16'd1, 32'd0, 32'd0, 32'h0000_0000);
            wait_idle();
            write_register(CFG_MAX_ITER, 16'hFFFF);
            send_pixel(16'hFFFE, 32'd0, 32'd0, 32'hFFFF_0000);
            send_pixel(16'hFFFF, 32'd0, 32'd0, 32'hFFFF_0000);
            in_valid <= 1'b0;
        end
    endtask

    task automatic test_palette_special_cases;
        begin
            wait_idle();
            write_register(CFG_MAX_ITER, 16'd100);
            write_register(CFG_PALETTE, 16'd1);
            write_register(CFG_PHASE, 16'd0);
            send_pixel(16'd5, 32'd0, 32'd0, 32'hFF00_0000);
            send_pixel(16'd5, 32'h0100_0000, 32'd0, 32'h8000_0000);
            send_pixel(16'd5, 32'h0200_0000, 32'h0200_0000, 32'h0000_0000);
            send_pixel(16'd5, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
            send_pixel(16'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678);
            send_pixel(16'd100, 32'h0300_0000, 32'd0, 32'hFFFF_FFFF);
            send_pixel(16'hFFFF, 32'hFF00_0000, 32'h0080_0000, 32'h00FF_FFFF);
            send_pixel(16'd0, 32'hFFFF_FFFF, 32'h0000_0001, 32'hABCD_EF01);
            wait_idle();
            write_register(CFG_PHASE, 16'hFFFF);
            send_pixel(16'd7, 32'h0280_0000, 32'hFE00_0000, 32'h0101_0101);
            send_pixel(16'd99, 32'h0100_0001, 32'd0, 32'hFEFE_FEFE);
            in_valid <= 1'b0;
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n);
        begin
            wait_idle();
            idle_sender_pct    = idle_pct;
            stall_receiver_pct = stall_pct;
            write_register(CFG_MAX_ITER, ($urandom_range(3) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(1, 300)));
            write_register(CFG_PALETTE, 16'($urandom_range(1)));
            write_register(CFG_PHASE, 16'($urandom));
            send_random_pixels(n);
        end
    endtask

    // Result checker and stall generator.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel_color %h", $realtime, pixel_color);
                error_count++;
            end
            else
            begin
                if (pixel_color !== expected_pixels[0])
                begin
                    $display("%0t: pixel_color expected %h actual %h", $realtime,
                             expected_pixels[0], pixel_color);
                    error_count++;
                end
                void'(expected_pixels.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_receiver_pct);
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("escape_time_pixel_colorizer_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_valid           = 1'b0;
        out_stall          = 1'b0;
        iter_count         = '0;
        z_real             = '0;
        z_imag             = '0;
        base_color         = '0;
        error_count        = 0;
        quiet_cycles       = 0;
        idle_sender_pct    = 0;
        stall_receiver_pct = 0;
        pred_max_iter      = MAX_ITER_RESET;
        pred_palette       = 1'b0;
        pred_phase         = 16'd0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_plain_ramp_extremes();
        test_palette_special_cases();
        test_random_phase(0, 0, 120);
        test_random_phase(79, 0, 120);
        test_random_phase(0, 79, 120);
        test_random_phase(22, 22, 140);
        wait_idle();

        if (error_count == 0)
            $display("escape_time_pixel_colorizer_test: clean");
        else
            $display("escape_time_pixel_colorizer_test: errors");
        $finish;
    end

endmodule
